/* src/lwpc_pkg.sv */
// Shared types and constants for the layer window priority compositor.
package lwpc_pkg;

    localparam int NUM_BG        = 4;
    localparam int BG_IDX_W      = $clog2(NUM_BG);
    localparam int COLOUR_W      = 16;
    localparam int PRI_W         = 2;
    localparam int COORD_W       = 8;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 3;

    localparam logic [COLOUR_W-1:0] TRANSPARENT_COLOUR = 16'h8000;
    localparam logic [PRI_W-1:0]    BACKDROP_PRI       = 2'h3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYER_WINDOW_ENABLES = 3'd0,
        REG_WIN0_BOUNDS          = 3'd1,
        REG_WIN1_BOUNDS          = 3'd2,
        REG_INSIDE_MASKS         = 3'd3,
        REG_OUTSIDE_MASK         = 3'd4,
        REG_BG_PRIORITIES        = 3'd5,
        REG_BACKDROP_COLOUR      = 3'd6
    } lwpc_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0]  line;
        logic [COORD_W-1:0]  column;
        logic [COLOUR_W-1:0] bg0_colour;
        logic [COLOUR_W-1:0] bg1_colour;
        logic [COLOUR_W-1:0] bg2_colour;
        logic [COLOUR_W-1:0] bg3_colour;
        logic [COLOUR_W-1:0] sprite_colour;
        logic [PRI_W-1:0]    sprite_priority;
    } lwpc_in_t;

    typedef struct packed {
        logic                write_pixel;
        logic [COLOUR_W-1:0] out_colour;
        logic [COORD_W-1:0]  out_line;
        logic [COORD_W-1:0]  out_column;
    } lwpc_out_t;

    typedef struct packed {
        logic [NUM_BG-1:0] layer_en;
        logic              write;
        logic              sprite_en;
    } lwpc_mask_t;

    typedef struct packed {
        logic             hit;
        logic [PRI_W-1:0] pri;
    } lwpc_lane_t;

    typedef struct packed {
        logic                hit;
        logic [PRI_W-1:0]    pri;
        logic [BG_IDX_W-1:0] idx;
    } lwpc_pick_t;

endpackage

/* src/layer_window_priority_compositor.sv */
// Top level of the layer window priority compositor.
// Takes one pixel item per clock while m_ready stays high and returns one result item for
// each, after both register stages. The first register stage holds the pixel with its
// window-masked layer enables; the second holds the result after four background lanes
// and the priority merge. Results leave in order; a stalled output holds the pipeline
// while free stages keep taking items. Configuration registers reset to zero and are
// written through cfg_we, cfg_idx and cfg_wdata, one register per write, no read-back.
module layer_window_priority_compositor
    import lwpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lwpc_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lwpc_out_t             m_data
);

    logic [7:0]          enables_reg;
    logic [31:0]         win0_reg;
    logic [31:0]         win1_reg;
    logic [7:0]          inside_reg;
    logic [3:0]          outside_reg;
    logic [7:0]          bg_pri_reg;
    logic [COLOUR_W-1:0] backdrop_reg;

    logic                st1_valid_reg;
    logic                st1_valid_next;
    lwpc_in_t            st1_data_reg;
    lwpc_mask_t          st1_mask_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    lwpc_out_t           out_data_reg;

    lwpc_mask_t          mask_d;
    logic                out_free;
    logic                st1_move;
    logic                s_take;

    lwpc_lane_t [NUM_BG-1:0]               lanes;
    logic       [NUM_BG-1:0][COLOUR_W-1:0] bg_colour;
    logic       [COLOUR_W-1:0]             colour;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enables_reg  <= '0;
            win0_reg     <= '0;
            win1_reg     <= '0;
            inside_reg   <= '0;
            outside_reg  <= '0;
            bg_pri_reg   <= '0;
            backdrop_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_LAYER_WINDOW_ENABLES: enables_reg  <= cfg_wdata[7:0];
                REG_WIN0_BOUNDS:          win0_reg     <= cfg_wdata;
                REG_WIN1_BOUNDS:          win1_reg     <= cfg_wdata;
                REG_INSIDE_MASKS:         inside_reg   <= cfg_wdata[7:0];
                REG_OUTSIDE_MASK:         outside_reg  <= cfg_wdata[3:0];
                REG_BG_PRIORITIES:        bg_pri_reg   <= cfg_wdata[7:0];
                REG_BACKDROP_COLOUR:      backdrop_reg <= cfg_wdata[COLOUR_W-1:0];
                default: ;
            endcase
        end
    end

    lwpc_window u_window (
        .enables      (enables_reg),
        .win0_bounds  (win0_reg),
        .win1_bounds  (win1_reg),
        .inside_masks (inside_reg),
        .outside_mask (outside_reg),
        .line         (s_data.line),
        .column       (s_data.column),
        .mask         (mask_d)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign st1_move = st1_valid_reg && out_free;
    assign s_ready  = !st1_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (s_take) begin
            st1_valid_next = 1'b1;
        end else if (st1_move) begin
            st1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (st1_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            st1_data_reg <= s_data;
            st1_mask_reg <= mask_d;
        end
    end

    assign bg_colour[0] = st1_data_reg.bg0_colour;
    assign bg_colour[1] = st1_data_reg.bg1_colour;
    assign bg_colour[2] = st1_data_reg.bg2_colour;
    assign bg_colour[3] = st1_data_reg.bg3_colour;

    for (genvar g = 0; g < NUM_BG; g++) begin : g_lane
        lwpc_lane u_lane (
            .colour   (bg_colour[g]),
            .layer_en (st1_mask_reg.layer_en[g]),
            .pri      (bg_pri_reg[g*PRI_W +: PRI_W]),
            .lane     (lanes[g])
        );
    end

    lwpc_merge u_merge (
        .lanes           (lanes),
        .bg_colour       (bg_colour),
        .backdrop_colour (backdrop_reg),
        .sprite_colour   (st1_data_reg.sprite_colour),
        .sprite_priority (st1_data_reg.sprite_priority),
        .mask            (st1_mask_reg),
        .colour          (colour)
    );

    always_ff @(posedge aclk) begin
        if (st1_move) begin
            out_data_reg.write_pixel <= st1_mask_reg.write;
            out_data_reg.out_colour  <= colour;
            out_data_reg.out_line    <= st1_data_reg.line;
            out_data_reg.out_column  <= st1_data_reg.column;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* src/lwpc_window.sv */
// Window hit test and background enable masking for one pixel.
module lwpc_window
    import lwpc_pkg::*;
(
    input  logic [7:0]            enables,
    input  logic [31:0]           win0_bounds,
    input  logic [31:0]           win1_bounds,
    input  logic [7:0]            inside_masks,
    input  logic [3:0]            outside_mask,
    input  logic [COORD_W-1:0]    line,
    input  logic [COORD_W-1:0]    column,
    output lwpc_mask_t            mask
);

    logic            hit0;
    logic            hit1;
    logic [3:0]      sel_mask;
    logic [4:0]      en_eff;

    assign hit0 = (column > win0_bounds[31:24]) && (column <= win0_bounds[23:16]) &&
                  (line > win0_bounds[15:8]) && (line <= win0_bounds[7:0]);
    assign hit1 = (column > win1_bounds[31:24]) && (column <= win1_bounds[23:16]) &&
                  (line > win1_bounds[15:8]) && (line <= win1_bounds[7:0]);

    always_comb begin
        if (enables[5] && hit0) begin
            sel_mask = inside_masks[3:0];
        end else if (enables[6] && hit1) begin
            sel_mask = inside_masks[7:4];
        end else begin
            sel_mask = outside_mask;
        end
        if (|enables[7:5]) begin
            en_eff = {1'b0, enables[3:0] & sel_mask};
        end else begin
            en_eff = enables[4:0];
        end
    end

    assign mask.layer_en  = en_eff[NUM_BG-1:0];
    assign mask.write     = |en_eff;
    assign mask.sprite_en = enables[4];

endmodule

/* src/lwpc_lane.sv */
// One background lane: decide whether the layer covers the pixel.
module lwpc_lane
    import lwpc_pkg::*;
(
    input  logic [COLOUR_W-1:0] colour,
    input  logic                layer_en,
    input  logic [PRI_W-1:0]    pri,
    output lwpc_lane_t          lane
);

    assign lane.hit = layer_en && (colour != TRANSPARENT_COLOUR);
    assign lane.pri = pri;

endmodule

/* src/lwpc_merge.sv */
// Merge the background lanes, the backdrop and the sprite into one colour.
module lwpc_merge
    import lwpc_pkg::*;
(
    input  lwpc_lane_t [NUM_BG-1:0]               lanes,
    input  logic       [NUM_BG-1:0][COLOUR_W-1:0] bg_colour,
    input  logic       [COLOUR_W-1:0]             backdrop_colour,
    input  logic       [COLOUR_W-1:0]             sprite_colour,
    input  logic       [PRI_W-1:0]                sprite_priority,
    input  lwpc_mask_t                            mask,
    output logic       [COLOUR_W-1:0]             colour
);

    function automatic lwpc_pick_t pick(lwpc_pick_t a, lwpc_pick_t b);
        if (b.hit && (!a.hit || (b.pri < a.pri))) begin
            return b;
        end
        return a;
    endfunction

    lwpc_pick_t                leaf [NUM_BG];
    lwpc_pick_t                lo;
    lwpc_pick_t                hi;
    lwpc_pick_t                win;
    logic [PRI_W-1:0]          best;
    logic [COLOUR_W-1:0]       bg_pick;

    always_comb begin
        for (int i = 0; i < NUM_BG; i++) begin
            leaf[i].hit = lanes[i].hit;
            leaf[i].pri = lanes[i].pri;
            leaf[i].idx = BG_IDX_W'(i);
        end
        lo  = pick(leaf[0], leaf[1]);
        hi  = pick(leaf[2], leaf[3]);
        win = pick(lo, hi);

        best    = win.hit ? win.pri : BACKDROP_PRI;
        bg_pick = win.hit ? bg_colour[win.idx] : backdrop_colour;

        if (!mask.write) begin
            colour = '0;
        end else if (mask.sprite_en && (sprite_colour != TRANSPARENT_COLOUR) &&
                     (sprite_priority <= best)) begin
            colour = sprite_colour;
        end else begin
            colour = bg_pick;
        end
    end

endmodule
